[hw/rtl/wsd_pkg.sv]
// shared types and constants of the websocket frame deframer
// no dependencies
`default_nettype none

package wsd_pkg;

	typedef enum logic [2:0] {
		PH_HDR0   = 3'd0,
		PH_HDR1   = 3'd1,
		PH_EXTLEN = 3'd2,
		PH_KEY    = 3'd3,
		PH_DATA   = 3'd4
	} phase_t;

	localparam logic [6:0] LEN_CODE_16 = 7'd126;
	localparam logic [6:0] LEN_CODE_64 = 7'd127;

	localparam logic [3:0] EXT_BYTES_16 = 4'd2;
	localparam logic [3:0] EXT_BYTES_64 = 4'd8;

	localparam logic [1:0] KEY_LAST_IDX = 2'd3;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       last_byte;
		logic       empty_frame;
	} result_t;

endpackage

`default_nettype wire

[hw/rtl/wsd_parser.sv]
// frame header parser, mask key capture and payload unmasking
// depends on wsd_pkg
`default_nettype none

module wsd_parser (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            accept,
	input  wire logic [7:0]      stream_byte,
	output logic                 res_valid,
	output wsd_pkg::result_t     res
);

	wsd_pkg::phase_t phase_q, phase_d;
	logic [3:0]  ext_left_q, ext_left_d, ext_dec;
	logic [63:0] plen_q, plen_d;
	logic [7:0]  mask_key_q [4];
	logic [1:0]  key_seen_q, key_seen_d;
	logic [63:0] rem_q, rem_d, rem_dec;
	logic [1:0]  midx_q, midx_d;
	logic        key_we;
	logic [6:0]  len_code;

	assign len_code = stream_byte[6:0];
	assign ext_dec  = ext_left_q - 4'd1;
	assign rem_dec  = rem_q - 64'd1;

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			wsd_pkg::PH_HDR1: begin
				if ((len_code == wsd_pkg::LEN_CODE_16) || (len_code == wsd_pkg::LEN_CODE_64))
					phase_d = wsd_pkg::PH_EXTLEN;
				else
					phase_d = wsd_pkg::PH_KEY;
			end
			wsd_pkg::PH_EXTLEN: begin
				if (ext_dec == 4'd0)
					phase_d = wsd_pkg::PH_KEY;
			end
			wsd_pkg::PH_KEY: begin
				if (key_seen_q == wsd_pkg::KEY_LAST_IDX)
					phase_d = (plen_q == 64'd0) ? wsd_pkg::PH_HDR0 : wsd_pkg::PH_DATA;
			end
			wsd_pkg::PH_DATA: begin
				if (rem_dec == 64'd0)
					phase_d = wsd_pkg::PH_HDR0;
			end
			default: begin
				// first header byte, also unused codes
				phase_d = wsd_pkg::PH_HDR1;
			end
		endcase
	end

	// datapath updates and result
	always_comb begin
		ext_left_d = ext_left_q;
		plen_d     = plen_q;
		key_seen_d = key_seen_q;
		rem_d      = rem_q;
		midx_d     = midx_q;
		key_we     = 1'b0;
		res_valid  = 1'b0;
		res        = '0;
		case (phase_q)
			wsd_pkg::PH_HDR1: begin
				key_seen_d = 2'd0;
				if (len_code == wsd_pkg::LEN_CODE_16) begin
					ext_left_d = wsd_pkg::EXT_BYTES_16;
					plen_d     = 64'd0;
				end else if (len_code == wsd_pkg::LEN_CODE_64) begin
					ext_left_d = wsd_pkg::EXT_BYTES_64;
					plen_d     = 64'd0;
				end else begin
					ext_left_d = 4'd0;
					plen_d     = {57'd0, len_code};
				end
			end
			wsd_pkg::PH_EXTLEN: begin
				plen_d     = {plen_q[55:0], stream_byte};
				ext_left_d = ext_dec;
			end
			wsd_pkg::PH_KEY: begin
				key_we = 1'b1;
				if (key_seen_q != wsd_pkg::KEY_LAST_IDX) begin
					key_seen_d = key_seen_q + 2'd1;
				end else begin
					key_seen_d = 2'd0;
					midx_d     = 2'd0;
					rem_d      = plen_q;
					if (plen_q == 64'd0) begin
						res_valid       = 1'b1;
						res.last_byte   = 1'b1;
						res.empty_frame = 1'b1;
					end
				end
			end
			wsd_pkg::PH_DATA: begin
				midx_d           = midx_q + 2'd1;
				rem_d            = rem_dec;
				res_valid        = 1'b1;
				res.payload_byte = stream_byte ^ mask_key_q[midx_q];
				res.last_byte    = (rem_dec == 64'd0);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= wsd_pkg::PH_HDR0;
			ext_left_q <= 4'd0;
			plen_q     <= 64'd0;
			key_seen_q <= 2'd0;
			rem_q      <= 64'd0;
			midx_q     <= 2'd0;
			for (int i = 0; i < 4; i++)
				mask_key_q[i] <= 8'd0;
		end else if (accept) begin
			phase_q    <= phase_d;
			ext_left_q <= ext_left_d;
			plen_q     <= plen_d;
			key_seen_q <= key_seen_d;
			rem_q      <= rem_d;
			midx_q     <= midx_d;
			if (key_we)
				mask_key_q[key_seen_q] <= stream_byte;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/websocket_frame_unmask_deframer_unit.sv]
// top level of the websocket frame deframer and unmasker
// depends on wsd_pkg and wsd_parser
`default_nettype none

// Takes a stream of masked websocket frames, one byte per request, and returns
// the unmasked payload bytes, one result per payload byte, with last_byte set
// on the final byte of each frame. A frame of zero length gives a single
// result with empty_frame and last_byte set and payload_byte zero. Header,
// extended length and mask key bytes give no other result. The fin, opcode
// and mask bits are ignored and a four byte mask key is always taken; 16 and
// 64 bit extended lengths are honored in full. One request is taken every
// cycle while in_stall is low: each byte updates the parser state and its
// result, formed combinationally, lands in an output register backed by one
// skid entry, so in_stall rises only when both are full while out_stall holds.

module websocket_frame_unmask_deframer_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] stream_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      payload_byte,
	output logic            last_byte,
	output logic            empty_frame
);

	logic             in_accept;
	logic             res_valid;
	wsd_pkg::result_t res;

	// output register and its skid entry
	logic             out_valid_q;
	wsd_pkg::result_t out_q;
	logic             skid_valid_q;
	wsd_pkg::result_t skid_q;
	logic             out_free;

	// stall only while the skid entry holds a result
	assign in_stall  = skid_valid_q;
	assign in_accept = in_valid && !skid_valid_q;

	wsd_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (in_accept),
		.stream_byte (stream_byte),
		.res_valid   (res_valid),
		.res         (res)
	);

	// output register can take a new result this cycle
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			// drain the skid entry first, no new request is taken meanwhile
			if (!out_stall)
				skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= in_accept && res_valid;
		end else if (in_accept && res_valid) begin
			// output held by the sink, park the new result
			skid_valid_q <= 1'b1;
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (!out_stall)
				out_q <= skid_q;
		end else if (out_free) begin
			if (in_accept && res_valid)
				out_q <= res;
		end else if (in_accept && res_valid) begin
			skid_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign payload_byte = out_q.payload_byte;
	assign last_byte    = out_q.last_byte;
	assign empty_frame  = out_q.empty_frame;

endmodule

`default_nettype wire
